@@ src/position_move_velocity_profiler_defines.svh @@
// Assertion macros used by the checker file of the velocity profiler.
`ifndef POSITION_MOVE_VELOCITY_PROFILER_DEFINES_SVH
`define POSITION_MOVE_VELOCITY_PROFILER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PMVP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("profiler assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PMVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("profiler assertion failed");

`endif

@@ src/pmvp_pkg.sv @@
`timescale 1ns / 1ps

package pmvp_pkg;

  // Fixed-point format and arrival hold time.
  localparam int FRAC_BITS  = 16;
  localparam int HOLD_TICKS = 8;

  // Field widths.
  localparam int POS_W    = 32;
  localparam int SPEED_W  = 21;
  localparam int MSPEED_W = 25;
  localparam int HOLD_W   = 4;
  localparam int ERR_W    = POS_W + 1;

  // The proportional zone ends at 12 units.
  localparam logic [ERR_W-1:0] DECEL_RANGE = ERR_W'(64'd12 << FRAC_BITS);
  localparam int PZ_ERR_W  = FRAC_BITS + 4;
  localparam int PROD_W    = SPEED_W + PZ_ERR_W;
  localparam int PSHIFT    = FRAC_BITS + 2;
  localparam int QX_W      = PROD_W - PSHIFT;

  // Division by three through a reciprocal, exact for inputs below 2^DIV3_SHIFT.
  localparam int DIV3_SHIFT = 25;
  localparam int DIV3_W     = DIV3_SHIFT - 1;
  localparam logic [DIV3_W-1:0] DIV3_MUL = DIV3_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

  localparam logic [HOLD_W-1:0] HOLD_MAX  = '1;
  localparam logic [HOLD_W-1:0] HOLD_DONE = HOLD_W'(HOLD_TICKS);

  // Register reset values.
  localparam logic [SPEED_W-1:0] MAX_VEL_RST = SPEED_W'(64'd1 << FRAC_BITS);
  localparam logic [SPEED_W-1:0] REACH_RST   = SPEED_W'(((64'd120 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SPEED_W-1:0] SETTLE_RST  = SPEED_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SPEED_W-1:0] MIN_VEL_RST = SPEED_W'(((64'd18 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [SPEED_W-1:0] STEP_RST    = SPEED_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);

  // Configuration port.
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_VEL   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_ENABLE    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_REACH     = 3'd3;
  localparam logic [INDEX_W-1:0] REG_SETTLE    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_MIN_VEL   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_STEP_UP   = 3'd6;
  localparam logic [INDEX_W-1:0] REG_STEP_DOWN = 3'd7;

  // Error comparisons carried down the pipeline.
  typedef struct packed {
    logic le_settle;
    logic ge_range;
    logic le_reach;
  } err_cmp_t;

endpackage

@@ src/position_move_velocity_profiler.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid / in_ready       shaft_angle
// out       source     out_valid / out_ready     motor_speed, output_speed, motor_target,
//                                                busy_res, arrived
// config    APB slave  psel, penable, pready     paddr, pwdata, prdata
// One beat enters per cycle while in_ready is high; it passes through the s1, s2, s3 and output registers.
// The four stages are input, error and product, divide by three, and ramp update.
// Only the last stage touches the ramp, hold and arrival state.
// A stalled output backs up stage by stage; in_ready drops only when all stages are full.
// Reset is synchronous and restores the configuration, profile state and valid registers; data registers are not reset.

module position_move_velocity_profiler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pmvp_pkg::POS_W-1:0]     shaft_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [pmvp_pkg::MSPEED_W-1:0]  motor_speed,
  output logic        [pmvp_pkg::SPEED_W-1:0]   output_speed,
  output logic signed [pmvp_pkg::POS_W-1:0]     motor_target,
  output logic                                  busy_res,
  output logic                                  arrived,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [pmvp_pkg::ADDR_W-1:0]    paddr,
  input  logic        [pmvp_pkg::DATA_W-1:0]    pwdata,
  output logic        [pmvp_pkg::DATA_W-1:0]    prdata,
  output logic                                  pready
);
  import pmvp_pkg::*;

  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

  // Configuration registers.
  logic signed [POS_W-1:0]   goal_position;
  logic        [SPEED_W-1:0] max_velocity;
  logic                      enable;
  logic        [SPEED_W-1:0] arrival_band;
  logic        [SPEED_W-1:0] settle_tolerance;
  logic        [SPEED_W-1:0] min_velocity;
  logic        [SPEED_W-1:0] step_up;
  logic        [SPEED_W-1:0] step_down;

  // Profile state.
  logic [SPEED_W-1:0] ramp_speed;
  logic [HOLD_W-1:0]  hold_count;
  logic               busy_flag;
  logic               arrived_flag;
  logic [SPEED_W-1:0] ramp_speed_next;
  logic [HOLD_W-1:0]  hold_count_next;
  logic               busy_flag_next;
  logic               arrived_flag_next;

  // Pipeline registers.
  logic                    s1_valid;
  logic signed [POS_W-1:0] s1_angle;
  logic                    s2_valid;
  err_cmp_t                s2_cmp;
  logic [QX_W-1:0]         s2_qx;
  logic                    s3_valid;
  err_cmp_t                s3_cmp;
  logic [SPEED_W-1:0]      s3_quot;
  logic [SPEED_W-1:0]      out_speed;
  logic signed [POS_W-1:0] out_target;
  logic                    out_busy;
  logic                    out_arrived;

  logic                    cfg_wr;
  logic [INDEX_W-1:0]      cfg_idx;
  logic                    out_ok;
  logic                    s3_ok;
  logic                    s2_ok;
  logic                    step_fire;

  logic signed [POS_W-1:0] pos;
  logic signed [ERR_W-1:0] diff;
  logic        [ERR_W-1:0] err;
  err_cmp_t                cmp;
  logic [PROD_W-1:0]       prod;
  logic [QX_W+DIV3_W-1:0]  div3_prod;
  logic [SPEED_W-1:0]      tgt_speed;
  logic signed [POS_W-1:0] target_neg;
  logic [MSPEED_W:0]       speed_x30;

  // Configuration port: writes land in the access phase, reads are combinational.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    unique case (cfg_idx)
      REG_TARGET:    prdata = DATA_W'(goal_position);
      REG_MAX_VEL:   prdata = DATA_W'(max_velocity);
      REG_ENABLE:    prdata = DATA_W'(enable);
      REG_REACH:     prdata = DATA_W'(arrival_band);
      REG_SETTLE:    prdata = DATA_W'(settle_tolerance);
      REG_MIN_VEL:   prdata = DATA_W'(min_velocity);
      REG_STEP_UP:   prdata = DATA_W'(step_up);
      REG_STEP_DOWN: prdata = DATA_W'(step_down);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_position    <= '0;
      max_velocity     <= MAX_VEL_RST;
      enable           <= 1'b0;
      arrival_band     <= REACH_RST;
      settle_tolerance <= SETTLE_RST;
      min_velocity     <= MIN_VEL_RST;
      step_up          <= STEP_RST;
      step_down        <= STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET:    goal_position    <= pwdata[POS_W-1:0];
        REG_MAX_VEL:   max_velocity     <= pwdata[SPEED_W-1:0];
        REG_ENABLE:    enable           <= pwdata[0];
        REG_REACH:     arrival_band     <= pwdata[SPEED_W-1:0];
        REG_SETTLE:    settle_tolerance <= pwdata[SPEED_W-1:0];
        REG_MIN_VEL:   min_velocity     <= pwdata[SPEED_W-1:0];
        REG_STEP_UP:   step_up          <= pwdata[SPEED_W-1:0];
        REG_STEP_DOWN: step_down        <= pwdata[SPEED_W-1:0];
        default:       ;
      endcase
    end
  end

  // Each stage loads when it is empty or the stage below it moves on.
  assign out_ok    = !out_valid || out_ready;
  assign s3_ok     = !s3_valid || out_ok;
  assign s2_ok     = !s2_valid || s3_ok;
  assign in_ready  = !s1_valid || s2_ok;
  assign step_fire = s3_valid && out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ok) begin
        s2_valid <= s1_valid;
      end
      if (s3_ok) begin
        s3_valid <= s2_valid;
      end
      if (out_ok) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Stage one: position, absolute error, comparisons and the speed product.
  always_comb begin
    pos  = (s1_angle == POS_MIN) ? POS_MAX : -s1_angle;
    diff = ERR_W'(goal_position) - ERR_W'(pos);
    err  = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    cmp.le_settle = err <= ERR_W'(settle_tolerance);
    cmp.ge_range  = err >= DECEL_RANGE;
    cmp.le_reach  = err <= ERR_W'(arrival_band);
    prod = PROD_W'(max_velocity) * PROD_W'(err[PZ_ERR_W-1:0]);
  end

  // Stage two: the remaining divide by three of the proportional speed.
  assign div3_prod = (QX_W+DIV3_W)'(s2_qx) * (QX_W+DIV3_W)'(DIV3_MUL);

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_angle <= shaft_angle;
    end
    if (s2_ok) begin
      s2_cmp <= cmp;
      s2_qx  <= prod[PROD_W-1:PSHIFT];
    end
    if (s3_ok) begin
      s3_cmp  <= s2_cmp;
      s3_quot <= div3_prod[DIV3_SHIFT +: SPEED_W];
    end
  end

  // Stage three: target speed, ramp step and arrival hold.
  always_comb begin
    if (s3_cmp.le_settle) begin
      tgt_speed = '0;
    end else if (s3_cmp.ge_range) begin
      tgt_speed = max_velocity;
    end else if (s3_quot < min_velocity) begin
      tgt_speed = min_velocity;
    end else if (s3_quot > max_velocity) begin
      tgt_speed = max_velocity;
    end else begin
      tgt_speed = s3_quot;
    end

    ramp_speed_next   = ramp_speed;
    hold_count_next   = hold_count;
    busy_flag_next    = busy_flag;
    arrived_flag_next = arrived_flag;

    if (!enable) begin
      ramp_speed_next   = '0;
      busy_flag_next    = 1'b0;
      arrived_flag_next = 1'b1;
    end else begin
      if (ramp_speed < tgt_speed) begin
        if (tgt_speed - ramp_speed > step_up) begin
          ramp_speed_next = ramp_speed + step_up;
        end else begin
          ramp_speed_next = tgt_speed;
        end
      end else begin
        if (ramp_speed - tgt_speed > step_down) begin
          ramp_speed_next = ramp_speed - step_down;
        end else begin
          ramp_speed_next = tgt_speed;
        end
      end

      if (s3_cmp.le_reach) begin
        if (hold_count != HOLD_MAX) begin
          hold_count_next = hold_count + 1'b1;
        end
        if (hold_count_next >= HOLD_DONE) begin
          busy_flag_next    = 1'b0;
          arrived_flag_next = 1'b1;
        end
      end else begin
        busy_flag_next    = 1'b1;
        arrived_flag_next = 1'b0;
        hold_count_next   = '0;
      end
    end
  end

  // State registers; target writes and enable writes that set the bit re-arm the move, clearing enable stops it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_speed   <= '0;
      hold_count   <= '0;
      busy_flag    <= 1'b0;
      arrived_flag <= 1'b1;
    end else if (cfg_wr && cfg_idx == REG_TARGET) begin
      busy_flag    <= 1'b1;
      arrived_flag <= 1'b0;
      hold_count   <= '0;
    end else if (cfg_wr && cfg_idx == REG_ENABLE) begin
      if (pwdata[0]) begin
        busy_flag    <= 1'b1;
        arrived_flag <= 1'b0;
        hold_count   <= '0;
      end else begin
        busy_flag    <= 1'b0;
        arrived_flag <= 1'b1;
        ramp_speed   <= '0;
      end
    end else if (step_fire) begin
      ramp_speed   <= ramp_speed_next;
      hold_count   <= hold_count_next;
      busy_flag    <= busy_flag_next;
      arrived_flag <= arrived_flag_next;
    end
  end

  // Result register.
  assign target_neg = (goal_position == POS_MIN) ? POS_MAX : -goal_position;

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_speed   <= ramp_speed_next;
      out_target  <= target_neg;
      out_busy    <= busy_flag_next;
      out_arrived <= arrived_flag_next;
    end
  end

  // Motor speed is thirty times the ramp speed, saturated to the port width.
  assign speed_x30 = {out_speed, 5'b0} - (MSPEED_W+1)'({out_speed, 1'b0});

  assign motor_speed  = speed_x30[MSPEED_W] ? '1 : speed_x30[MSPEED_W-1:0];
  assign output_speed = out_speed;
  assign motor_target = out_target;
  assign busy_res     = out_busy;
  assign arrived      = out_arrived;

endmodule

@@ src/pmvp_checker.sv @@
`timescale 1ns / 1ps
`include "position_move_velocity_profiler_defines.svh"

module pmvp_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic        [pmvp_pkg::MSPEED_W-1:0]  motor_speed,
  input logic        [pmvp_pkg::SPEED_W-1:0]   output_speed,
  input logic                                  busy_res,
  input logic                                  arrived
);
  import pmvp_pkg::*;

  logic [MSPEED_W:0] speed_x30;
  logic [MSPEED_W-1:0] speed_exp;

  assign speed_x30 = (MSPEED_W+1)'(output_speed) * (MSPEED_W+1)'(30);
  assign speed_exp = speed_x30[MSPEED_W] ? '1 : speed_x30[MSPEED_W-1:0];

  // A result beat always reports exactly one of busy and arrived.
  `PMVP_ASSERT_IMPLY(a_busy_xor_arrived, clk, rst, out_valid, busy_res != arrived)

  // The motor command follows the reported ramp speed.
  `PMVP_ASSERT_IMPLY(a_motor_speed, clk, rst, out_valid, motor_speed == speed_exp)

  // Input stalls only when a finished result is being held back.
  `PMVP_ASSERT_IMPLY(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)

  // A result beat that is not taken stays put.
  `PMVP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(output_speed) && $stable(busy_res))

endmodule

bind position_move_velocity_profiler pmvp_checker u_pmvp_checker (.*);
